// ----- design/personal_id_date_luhn_check_assert.svh -----
// Assertion macros used by the checker top level.
`ifndef PERSONAL_ID_DATE_LUHN_CHECK_ASSERT_SVH
`define PERSONAL_ID_DATE_LUHN_CHECK_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define PIDL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define PIDL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/pidl_pkg.sv -----
// Types, constants and helper functions of the identity number checker.
package pidl_pkg;

	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned POS_W   = 4;
	localparam int unsigned DIGIT_W = 4;
	localparam int unsigned YEAR_W  = 7;

	localparam logic [POS_W-1:0] POS_YEAR_T  = 4'd0;
	localparam logic [POS_W-1:0] POS_YEAR_U  = 4'd1;
	localparam logic [POS_W-1:0] POS_MONTH_T = 4'd2;
	localparam logic [POS_W-1:0] POS_MONTH_U = 4'd3;
	localparam logic [POS_W-1:0] POS_DAY_T   = 4'd4;
	localparam logic [POS_W-1:0] POS_DAY_U   = 4'd5;
	localparam logic [POS_W-1:0] POS_HYPHEN  = 4'd6;
	localparam logic [POS_W-1:0] POS_SER_0   = 4'd7;
	localparam logic [POS_W-1:0] POS_SER_2   = 4'd9;
	localparam logic [POS_W-1:0] POS_LAST    = 4'd10;
	localparam logic [POS_W-1:0] POS_DONE    = 4'd11;

	localparam logic [CHAR_W-1:0] CHAR_HYPHEN = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;

	localparam logic [YEAR_W-1:0] PIVOT_RESET = 7'd24;
	localparam logic [4:0]        FEB_LEAP_LEN = 5'd29;
	localparam logic [3:0]        MONTH_FEB = 4'd2;
	localparam logic [3:0]        MONTH_MAX = 4'd12;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_CHAR  = 3'd1,
		ST_BAD_MONTH = 3'd2,
		ST_BAD_DAY   = 3'd3,
		ST_BAD_CHECK = 3'd4
	} status_t;

	// The running Luhn sum is kept modulo ten, which is all the check digit needs.
	typedef struct packed {
		logic [POS_W-1:0]   pos;
		logic [DIGIT_W-1:0] tens;
		logic               leap;
		logic [3:0]         month;
		logic [3:0]         lsum;
		status_t            ferr;
	} state_t;

	typedef struct packed {
		logic               valid_res;
		status_t            status;
		logic [DIGIT_W-1:0] computed_check;
	} res_t;

	localparam state_t STATE_CLEAR = '{
		pos: '0, tens: '0, leap: 1'b0, month: '0, lsum: '0, ferr: ST_OK
	};

	// Month length; codes outside 1 to 12 wrap around the table as the index does.
	function automatic logic [4:0] month_len(input logic [3:0] m);
		logic [4:0] len;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12, 4'd13, 4'd15: len = 5'd31;
			4'd2, 4'd14: len = 5'd28;
			default: len = 5'd30;
		endcase
		return len;
	endfunction

endpackage

// ----- design/pidl_in_if.sv -----
// Input channel: one character item per handshake.
interface pidl_in_if;
	logic                       valid;
	logic                       ready;
	logic [pidl_pkg::CHAR_W-1:0] char_code;
	logic                       start_req;

	modport source (output valid, char_code, start_req, input ready);
	modport sink (input valid, char_code, start_req, output ready);
endinterface

// ----- design/pidl_out_if.sv -----
// Result channel: one verdict item per identity number.
interface pidl_out_if;
	logic                        valid;
	logic                        ready;
	logic                        valid_res;
	logic [2:0]                  status;
	logic [pidl_pkg::DIGIT_W-1:0] computed_check;

	modport source (output valid, valid_res, status, computed_check, input ready);
	modport sink (input valid, valid_res, status, computed_check, output ready);
endinterface

// ----- design/pidl_cfg_if.sv -----
// Configuration channel carrying the pivot year.
interface pidl_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [pidl_pkg::YEAR_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- design/personal_id_date_luhn_check.sv -----
// Top level of the identity number checker for the form YYMMDD-NNNN.
//
// Characters arrive one per item on item_in; start_req marks the first character
// of a new number and clears the per-number state. After the eleventh character
// one item leaves on item_out with the verdict, the first error and the
// computed Luhn check digit. Characters after the eleventh that carry no
// start_req are consumed and give no result.
// The pivot year is written through cfg by the user only while the block is idle;
// the block does not enforce this, and cfg is always ready. Reset sets the pivot
// year to 24 and clears the per-number state. Each item passes an input register
// and is evaluated against the running state; the verdict is registered. One
// character is accepted in every cycle unless a final character waits on a
// stalled result; the state update is a single pass of small per-position
// logic. When the receiver stalls, the result register holds its item,
// characters that give no result still flow, and a final character waits in
// the input register, after which item_in.ready drops until the result is taken.
`include "personal_id_date_luhn_check_assert.svh"

module personal_id_date_luhn_check (
	input  logic       clk,
	input  logic       arst_n,
	pidl_in_if.sink    item_in,
	pidl_out_if.source item_out,
	pidl_cfg_if.sink   cfg
);
	import pidl_pkg::*;

	logic                v_s1;
	logic [CHAR_W-1:0]   char_s1;
	logic                start_s1;
	logic [YEAR_W-1:0]   pivot_q;
	state_t              state_q;
	state_t              nxt_state;
	logic                emit;
	res_t                res;
	logic                out_valid_q;
	res_t                res_q;
	logic                out_free;
	logic                consume;
	logic                take_in;

	pidl_step u_step (
		.char_code (char_s1),
		.start_req (start_s1),
		.pivot_year(pivot_q),
		.cur_state (state_q),
		.nxt_state (nxt_state),
		.emit      (emit),
		.res       (res)
	);

	assign out_free = !out_valid_q || item_out.ready;
	assign consume = v_s1 && (!emit || out_free);
	assign item_in.ready = !v_s1 || consume;
	assign take_in = item_in.valid && item_in.ready;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			pivot_q <= PIVOT_RESET;
			state_q <= STATE_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (take_in) v_s1 <= 1'b1;
			else if (consume) v_s1 <= 1'b0;
			if (cfg.valid) pivot_q <= cfg.data;
			if (consume) state_q <= nxt_state;
			if (consume && emit) out_valid_q <= 1'b1;
			else if (item_out.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			char_s1 <= item_in.char_code;
			start_s1 <= item_in.start_req;
		end
		if (consume && emit) res_q <= res;
	end

	assign item_out.valid = out_valid_q;
	assign item_out.valid_res = res_q.valid_res;
	assign item_out.status = res_q.status;
	assign item_out.computed_check = res_q.computed_check;

	`PIDL_ASSERT_NOW(a_verdict_matches_status, out_valid_q,
		res_q.valid_res == (res_q.status == ST_OK), "verdict disagrees with status")
	`PIDL_ASSERT_NOW(a_check_digit_range, out_valid_q,
		res_q.computed_check <= 4'd9, "check digit out of range")
	`PIDL_ASSERT_NEXT(a_done_after_result, consume && emit,
		state_q.pos == POS_DONE && out_valid_q, "state not idle after result")
	`PIDL_ASSERT_NEXT(a_stage_holds, v_s1 && !consume,
		v_s1 && $stable(char_s1) && $stable(start_s1), "input stage lost an item")
endmodule

// ----- design/pidl_step.sv -----
// Next-state and verdict logic for one character.
module pidl_step (
	input  logic [pidl_pkg::CHAR_W-1:0] char_code,
	input  logic                        start_req,
	input  logic [pidl_pkg::YEAR_W-1:0] pivot_year,
	input  pidl_pkg::state_t            cur_state,
	output pidl_pkg::state_t            nxt_state,
	output logic                        emit,
	output pidl_pkg::res_t              res
);
	import pidl_pkg::*;

	state_t       cur;
	logic         active;
	logic         is_dig;
	logic [3:0]   d;
	logic [6:0]   val;
	logic         century19;
	logic         weight2;
	logic [4:0]   dbl;
	logic [4:0]   lterm;
	logic [4:0]   lsum_raw;
	logic [3:0]   check;
	logic [4:0]   len;
	status_t      err;

	always_comb begin
		cur = start_req ? STATE_CLEAR : cur_state;
		active = (cur.pos < POS_DONE);
		is_dig = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
		d = is_dig ? char_code[3:0] : 4'd0;
		val = {cur.tens, 3'b000} + {2'b00, cur.tens, 1'b0} + {3'b000, d};
		century19 = (val > pivot_year);
		weight2 = (cur.pos == POS_YEAR_T) || (cur.pos == POS_MONTH_T)
			|| (cur.pos == POS_DAY_T) || (cur.pos == POS_SER_0) || (cur.pos == POS_SER_2);
		dbl = {d, 1'b0};
		lterm = weight2 ? ((dbl > 5'd9) ? dbl - 5'd9 : dbl) : {1'b0, d};
		lsum_raw = {1'b0, cur.lsum} + lterm;
		check = (cur.lsum == 4'd0) ? 4'd0 : 4'd10 - cur.lsum;
		len = ((cur.month == MONTH_FEB) && cur.leap) ? FEB_LEAP_LEN : month_len(cur.month);

		nxt_state = cur;
		err = cur.ferr;
		emit = 1'b0;

		if (cur.pos == POS_HYPHEN) begin
			if ((char_code != CHAR_HYPHEN) && (err == ST_OK)) err = ST_BAD_CHAR;
		end else if (!is_dig && (err == ST_OK)) begin
			err = ST_BAD_CHAR;
		end

		unique case (cur.pos)
			POS_YEAR_T, POS_MONTH_T, POS_DAY_T: begin
				nxt_state.tens = d;
			end
			POS_YEAR_U: begin
				nxt_state.leap = (val[1:0] == 2'b00) && !(century19 && (val == 7'd0));
			end
			POS_MONTH_U: begin
				if (err == ST_OK) begin
					if ((val < 7'd1) || (val > {3'b000, MONTH_MAX})) err = ST_BAD_MONTH;
					else nxt_state.month = val[3:0];
				end
			end
			POS_DAY_U: begin
				if ((err == ST_OK) && ((val < 7'd1) || (val > {2'b00, len}))) begin
					err = ST_BAD_DAY;
				end
			end
			POS_LAST: begin
				if ((err == ST_OK) && (d != check)) err = ST_BAD_CHECK;
			end
			default: begin
			end
		endcase

		if ((cur.pos < POS_LAST) && (cur.pos != POS_HYPHEN)) begin
			nxt_state.lsum = (lsum_raw >= 5'd10) ? 4'(lsum_raw - 5'd10) : lsum_raw[3:0];
		end

		nxt_state.ferr = err;
		if (cur.pos == POS_LAST) begin
			nxt_state.pos = POS_DONE;
			emit = 1'b1;
		end else begin
			nxt_state.pos = cur.pos + 4'd1;
		end

		if (!active) begin
			nxt_state = cur;
			emit = 1'b0;
		end

		res.valid_res = (err == ST_OK);
		res.status = err;
		res.computed_check = check;
	end
endmodule

// ----- tb/pidl_verdict_checker.sv -----
`timescale 1ns / 100ps
// Checker that predicts the verdict of every identity number from the accepted items and compares.
module pidl_verdict_checker (
	input  logic clk,
	input  logic arst_n,
	pidl_in_if   chars,
	pidl_out_if  verdicts,
	pidl_cfg_if  pivot_wr,
	output int   fail_count,
	output int   awaited
);
	import pidl_pkg::*;

	int days_in_month [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	logic [YEAR_W-1:0]  pivot;
	logic [POS_W-1:0]   pos;
	logic [DIGIT_W-1:0] tens;
	logic               leap;
	logic [3:0]         month;
	logic [6:0]         lsum;
	status_t            ferr;
	res_t               verdict_q [$];
	res_t               want;
	int                 errs = 0;

	task automatic report(input string msg);
		errs++;
		$display("%0t ns: %s", $time, msg);
	endtask

	task automatic clear_number();
		pos = '0;
		tens = '0;
		leap = 1'b0;
		month = '0;
		lsum = '0;
		ferr = ST_OK;
	endtask

	task automatic absorb(input logic [CHAR_W-1:0] c, input logic st);
		int d, v, yy, y, val, len;
		logic [7:0] mi;
		logic [POS_W-1:0] p;
		bit dig;
		res_t r;
		if (st)
			clear_number();
		if (pos > POS_LAST)
			return;
		p = pos;
		dig = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
		d = dig ? int'(c - CHAR_ZERO) : 0;
		if (p == POS_HYPHEN) begin
			if (c != CHAR_HYPHEN && ferr == ST_OK)
				ferr = ST_BAD_CHAR;
		end else if (!dig && ferr == ST_OK) begin
			ferr = ST_BAD_CHAR;
		end
		val = int'(tens) * 10 + d;
		if (p == POS_YEAR_T || p == POS_MONTH_T || p == POS_DAY_T) begin
			tens = DIGIT_W'(d);
		end else if (p == POS_YEAR_U) begin
			yy = val;
			y = (yy > int'(pivot)) ? 1900 + yy : 2000 + yy;
			leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		end else if (p == POS_MONTH_U) begin
			if (ferr == ST_OK) begin
				if (val < 1 || val > int'(MONTH_MAX))
					ferr = ST_BAD_MONTH;
				else
					month = 4'(val);
			end
		end else if (p == POS_DAY_U) begin
			if (ferr == ST_OK) begin
				mi = {4'd0, month} - 8'd1;
				len = days_in_month[mi % 12];
				if (month == MONTH_FEB && leap)
					len = int'(FEB_LEAP_LEN);
				if (val < 1 || val > len)
					ferr = ST_BAD_DAY;
			end
		end
		if (p < POS_LAST && p != POS_HYPHEN) begin
			v = d;
			if (p == POS_YEAR_T || p == POS_MONTH_T || p == POS_DAY_T || p == POS_SER_0
					|| p == POS_SER_2) begin
				v = 2 * d;
				if (v > 9)
					v = v - 9;
			end
			lsum = 7'(int'(lsum) + v);
		end
		if (p == POS_LAST) begin
			r.computed_check = DIGIT_W'((10 - int'(lsum) % 10) % 10);
			if (ferr == ST_OK && d != int'(r.computed_check))
				ferr = ST_BAD_CHECK;
			r.valid_res = (ferr == ST_OK);
			r.status = ferr;
			verdict_q.push_back(r);
			pos = POS_DONE;
			return;
		end
		pos = p + 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pivot = PIVOT_RESET;
			clear_number();
			verdict_q.delete();
		end else begin
			if (verdicts.valid && verdicts.ready) begin
				if (verdict_q.size() == 0) begin
					report("result item arrived with no verdict pending");
				end else begin
					want = verdict_q.pop_front();
					if (verdicts.valid_res !== want.valid_res)
						report($sformatf("valid_res got %0d expected %0d",
							verdicts.valid_res, want.valid_res));
					if (verdicts.status !== want.status)
						report($sformatf("status got %0d expected %0d",
							verdicts.status, want.status));
					if (verdicts.computed_check !== want.computed_check)
						report($sformatf("computed_check got %0d expected %0d",
							verdicts.computed_check, want.computed_check));
				end
			end
			if (pivot_wr.valid && pivot_wr.ready)
				pivot = pivot_wr.data;
			if (chars.valid && chars.ready)
				absorb(chars.char_code, chars.start_req);
		end
		awaited <= verdict_q.size();
		fail_count <= errs;
	end

endmodule

// ----- tb/tb_personal_id_date_luhn_check.sv -----
`timescale 1ns / 100ps
// Testbench top: drives identity number characters, pivot writes and result stalls.
module tb_personal_id_date_luhn_check;
	import pidl_pkg::*;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int RANDOM_CHARS = 640;
	localparam int PHASES       = 5;

	typedef logic [CHAR_W-1:0] char_seq_t [$];

	logic              clk;
	logic              arst_n;
	int                fail_count;
	int                awaited;
	int                chars_sent = 0;
	bit                in_burst = 1'b0;
	bit                out_burst = 1'b0;
	logic [YEAR_W-1:0] pivot_now;

	pidl_in_if  in_ch ();
	pidl_out_if out_ch ();
	pidl_cfg_if cfg_ch ();

	personal_id_date_luhn_check DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_in  (in_ch),
		.item_out (out_ch),
		.cfg      (cfg_ch)
	);

	pidl_verdict_checker u_verdicts (
		.clk        (clk),
		.arst_n     (arst_n),
		.chars      (in_ch),
		.verdicts   (out_ch),
		.pivot_wr   (cfg_ch),
		.fail_count (fail_count),
		.awaited    (awaited)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int unsigned stall;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 7) == 0)
				out_burst = !out_burst;
			stall = out_burst ? 0 : $urandom_range(0, 9);
			if (stall != 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (out_ch.valid !== 1'b1);
		end
	end

	task automatic send_char(input logic [CHAR_W-1:0] c, input logic st);
		int unsigned gap;
		gap = in_burst ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.char_code <= c;
		in_ch.start_req <= st;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		chars_sent++;
	endtask

	task automatic send_seq(input char_seq_t s, input logic st);
		foreach (s[i])
			send_char(s[i], (i == 0) ? st : 1'b0);
	endtask

	function automatic char_seq_t to_seq(input string t);
		char_seq_t s;
		for (int i = 0; i < t.len(); i++)
			s.push_back(t[i]);
		return s;
	endfunction

	// Appends the correct Luhn digit to the first ten characters of a number.
	function automatic string with_check(input string t);
		int sum, v;
		sum = 0;
		for (int i = 0; i < 10; i++) begin
			if (i != POS_HYPHEN) begin
				v = int'(t[i]) - int'(CHAR_ZERO);
				if (i == POS_YEAR_T || i == POS_MONTH_T || i == POS_DAY_T || i == POS_SER_0
						|| i == POS_SER_2) begin
					v = 2 * v;
					if (v > 9)
						v = v - 9;
				end
				sum += v;
			end
		end
		return $sformatf("%s%0d", t, (10 - sum % 10) % 10);
	endfunction

	task automatic send_text(input string t, input logic st);
		in_burst = ($urandom_range(0, 2) == 0);
		send_seq(to_seq(t), st);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (awaited != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_pivot(input logic [YEAR_W-1:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
		pivot_now = v;
	endtask

	task automatic random_number();
		int unsigned kind, yy, mm, dd;
		char_seq_t s;
		in_burst = ($urandom_range(0, 3) == 0);
		kind = $urandom_range(0, 99);
		if (kind >= 94) begin
			repeat ($urandom_range(1, 6))
				send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			return;
		end
		if ($urandom_range(0, 4) == 0 && pivot_now < 99)
			yy = pivot_now + $urandom_range(0, 1);
		else
			yy = $urandom_range(0, 99);
		mm = $urandom_range(1, 12);
		dd = ($urandom_range(0, 4) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28);
		if ($urandom_range(0, 9) == 0) begin
			mm = 2;
			dd = 29;
		end
		s = to_seq(with_check($sformatf("%02d%02d%02d-%03d", yy, mm, dd,
			$urandom_range(0, 999))));
		if (kind >= 60 && kind < 70)
			s[10] = 8'(CHAR_ZERO + $urandom_range(0, 9));
		else if (kind >= 70 && kind < 80)
			s[$urandom_range(0, 10)] = 8'($urandom_range(0, 255));
		else if (kind >= 80 && kind < 88)
			s[$urandom_range(2, 5)] = 8'(CHAR_ZERO + $urandom_range(0, 9));
		else if (kind >= 88)
			s = s[0:$urandom_range(0, 9)];
		send_seq(s, $urandom_range(0, 19) != 0);
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 3))
				send_char(8'($urandom_range(0, 255)), 1'b0);
	endtask

	initial begin
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.char_code <= '0;
		in_ch.start_req <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= '0;
		pivot_now = PIVOT_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The first number after reset carries no start_req.
		send_text(with_check("811218-987"), 1'b0);
		send_text(with_check("000229-123"), 1'b1);
		send_text(with_check("960229-456"), 1'b1);
		send_text(with_check("230229-111"), 1'b1);
		send_text("991301-0000", 1'b1);
		send_text("990001-0000", 1'b1);
		send_text("990100-0000", 1'b1);
		send_text("990132-0000", 1'b1);
		send_text("990431-0000", 1'b1);
		send_text(with_check("991231-999"), 1'b1);
		send_text("811218-9870", 1'b1);
		send_text("9912a1-0000", 1'b1);
		send_text("991231+0000", 1'b1);
		send_text("991301-00a0", 1'b1);
		send_text("99a301-0000", 1'b1);
		send_text("99999999999", 1'b1);
		send_text("12345", 1'b0);
		send_text("8112", 1'b1);
		send_text(with_check("240101-000"), 1'b1);
		send_char(8'hFF, 1'b1);
		repeat (10) send_char(8'h00, 1'b0);
		drain();

		chars_sent = 0;
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: write_pivot(7'd0);
				1: write_pivot(7'd99);
				2: write_pivot(7'd127);
				default: write_pivot(7'($urandom_range(0, 99)));
			endcase
			while (chars_sent < (ph + 1) * RANDOM_CHARS / PHASES)
				random_number();
			drain();
		end

		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
